// ----- rtl/core/cod_pkg.sv -----
// Shared constants and types for the colour outline dilation block.
`timescale 1ns / 1ps
package cod_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 4;

  localparam int PIX_W     = 32;
  localparam int RADIUS_W  = 3;
  localparam int DIM_W     = 11;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLINE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [PIX_W-1:0]    MATCH_RST   = 32'hFFFF_FFFF;
  localparam logic [PIX_W-1:0]    OUTLINE_RST = 32'hFFFF_0000;
  localparam logic [RADIUS_W-1:0] RADIUS_RST  = 3'd1;
  localparam logic [DIM_W-1:0]    DIM_RST     = 11'd1024;

  typedef struct packed {
    logic step;
    logic emit;
    logic last;
    logic real_pix;
    logic fbit;
  } cod_step_t;

endpackage

// ----- rtl/core/cod_in_if.sv -----
// Input channel: pixel and flush transactions.
`timescale 1ns / 1ps
interface cod_in_if
  import cod_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// ----- rtl/core/cod_out_if.sv -----
// Result channel: output pixel transactions.
`timescale 1ns / 1ps
interface cod_out_if
  import cod_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

// ----- rtl/core/cod_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cod_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/cod_cell.sv -----
// One cell of the horizontal window chain.
`timescale 1ns / 1ps
module cod_cell
  import cod_pkg::*;
#(
  parameter int RW = $clog2(MAX_HEIGHT_DEF + 2 * MAX_RADIUS_DEF + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr_i,
  input  logic          en_i,
  input  logic          d_valid_i,
  input  logic          d_vor_i,
  input  logic          d_fbit_i,
  input  logic [RW-1:0] d_row_i,
  output logic          q_valid_o,
  output logic          q_vor_o,
  output logic          q_fbit_o,
  output logic [RW-1:0] q_row_o,
  input  logic [RW-1:0] ctr_row_i,
  input  logic          ctr_fbit_i,
  input  logic          win_i,
  output logic          hit_o
);

  logic          valid_r;
  logic          vor_r;
  logic          fbit_r;
  logic [RW-1:0] row_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr_i) begin
      valid_r <= 1'b0;
    end else if (en_i) begin
      valid_r <= d_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      vor_r  <= d_vor_i;
      fbit_r <= d_fbit_i;
      row_r  <= d_row_i;
    end
  end

  assign q_valid_o = valid_r;
  assign q_vor_o   = vor_r;
  assign q_fbit_o  = fbit_r;
  assign q_row_o   = row_r;

  // same line of the same frame, inside the window
  assign hit_o = win_i && valid_r && vor_r && (fbit_r == ctr_fbit_i) && (row_r == ctr_row_i);

endmodule

// ----- rtl/core/cod_seq.sv -----
// Position counters and step sequencing for the dilation pipeline.
`timescale 1ns / 1ps
module cod_seq
  import cod_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1),
  localparam int HW  = $clog2(MAX_HEIGHT),
  localparam int WEW = $clog2(MAX_WIDTH + 1),
  localparam int HEW = $clog2(MAX_HEIGHT + 1),
  localparam int LW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1),
  localparam int PD  = (MAX_RADIUS + 1) * MAX_WIDTH,
  localparam int PW  = $clog2(PD)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           restart_i,
  input  logic           adv_i,
  input  logic           in_valid_i,
  input  logic           req_type_i,
  input  logic [WEW-1:0] w_i,
  input  logic [HEW-1:0] h_i,
  input  logic [LW-1:0]  lag_i,
  output logic           in_ready_o,
  output cod_step_t      ctl_o,
  output logic [CW-1:0]  pcol_o,
  output logic [RW-1:0]  prow_o,
  output logic [PW-1:0]  wptr_o,
  output logic [PW-1:0]  rptr_o
);

  logic [CW-1:0] pcol_r, pcol_nxt;
  logic [RW-1:0] prow_r, prow_nxt;
  logic [CW-1:0] ocol_r, ocol_nxt;
  logic [HW-1:0] orow_r, orow_nxt;
  logic [LW-1:0] pre_r, pre_nxt;
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic          owe_r, owe_nxt;
  logic          fbit_r, fbit_nxt;

  logic in_done, ready, accept, real_pix, step, at_lag, emit;
  logic col_end, row_last_in, last, ocol_end;

  always_comb begin
    in_done     = prow_r >= RW'(h_i);
    ready       = adv_i && !owe_r;
    accept      = in_valid_i && ready;
    real_pix    = accept && (req_type_i == REQ_PIXEL) && !in_done;
    step        = real_pix || (accept && in_done) || (adv_i && owe_r);
    at_lag      = pre_r == lag_i;
    emit        = step && at_lag;
    col_end     = pcol_r == CW'(w_i - 1'b1);
    row_last_in = prow_r == RW'(h_i - 1'b1);
    ocol_end    = ocol_r == CW'(w_i - 1'b1);
    last        = (orow_r == HW'(h_i - 1'b1)) && ocol_end;

    pcol_nxt = pcol_r;
    prow_nxt = prow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    pre_nxt  = pre_r;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    owe_nxt  = owe_r;
    fbit_nxt = fbit_r;

    if (step) begin
      if (col_end) begin
        pcol_nxt = '0;
        prow_nxt = prow_r + 1'b1;
      end else begin
        pcol_nxt = pcol_r + 1'b1;
      end
      if (!at_lag) begin
        pre_nxt = pre_r + 1'b1;
      end
    end
    if (real_pix) begin
      wptr_nxt = (wptr_r == PW'(PD - 1)) ? '0 : wptr_r + 1'b1;
    end
    // frame complete before the pipeline has filled: run empty steps until the first result
    if (real_pix && col_end && row_last_in && !at_lag) begin
      owe_nxt = 1'b1;
    end
    if (emit) begin
      rptr_nxt = (rptr_r == PW'(PD - 1)) ? '0 : rptr_r + 1'b1;
      owe_nxt  = 1'b0;
      if (ocol_end) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + 1'b1;
      end else begin
        ocol_nxt = ocol_r + 1'b1;
      end
    end
    if ((emit && last) || restart_i) begin
      pcol_nxt = '0;
      prow_nxt = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
      pre_nxt  = '0;
      wptr_nxt = '0;
      rptr_nxt = '0;
      owe_nxt  = 1'b0;
      fbit_nxt = !fbit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcol_r <= '0;
      prow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      pre_r  <= '0;
      wptr_r <= '0;
      rptr_r <= '0;
      owe_r  <= 1'b0;
      fbit_r <= 1'b0;
    end else begin
      pcol_r <= pcol_nxt;
      prow_r <= prow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      pre_r  <= pre_nxt;
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      owe_r  <= owe_nxt;
      fbit_r <= fbit_nxt;
    end
  end

  assign in_ready_o     = ready;
  assign ctl_o.step     = step;
  assign ctl_o.emit     = emit;
  assign ctl_o.last     = last;
  assign ctl_o.real_pix = real_pix;
  assign ctl_o.fbit     = fbit_r;
  assign pcol_o         = pcol_r;
  assign prow_o         = prow_r;
  assign wptr_o         = wptr_r;
  assign rptr_o         = rptr_r;

endmodule

// ----- rtl/core/color_outline_dilation.sv -----
// Top level of the colour outline dilation block.
// Usage:
//   in_ch  : raster-order transactions; req_type 0 carries a pixel, 1 is a flush.
//   out_ch : one result pixel per emitted transaction, last_of_frame on the final one.
//   cfg_*  : register writes (match, outline, radius, width, height); each valid
//            write restarts the frame. Write only while the block is idle.
// Results: result k leaves with the transaction carrying pixel k + radius*width +
//   radius, through the stage B, stage C and output registers; flush transactions
//   drain the tail of the frame, one result each.
// Throughput: one transaction per cycle while out_ch is not held; the column
//   store is read and written in the same cycle, with a bypass when both hit
//   one column. When a whole frame is shorter than the window lag, the last
//   pixel is followed by internal steps with in_ch.ready low until the first result.
// Reset: registers take their defaults, counters clear; the stores need no clearing.
// Stall: when out_ch is held, the whole pipeline and in_ch.ready hold with it.
`timescale 1ns / 1ps
module color_outline_dilation
  import cod_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cod_in_if.sink               in_ch,
  cod_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int HEW = $clog2(MAX_HEIGHT + 1);
  localparam int RDW = $clog2(MAX_RADIUS + 1);
  localparam int LW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int PD  = (MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int PW  = $clog2(PD);
  localparam int MVW = 2 * MAX_RADIUS;
  localparam int VW  = MVW + 1;
  localparam int NC  = 2 * MAX_RADIUS + 1;
  localparam int NCW = $clog2(NC);

  logic [PIX_W-1:0]    match_r, outline_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [DIM_W-1:0]    width_r, height_r;
  logic                restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r   <= MATCH_RST;
      outline_r <= OUTLINE_RST;
      radius_r  <= RADIUS_RST;
      width_r   <= DIM_RST;
      height_r  <= DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH:   match_r   <= cfg_data;
        REG_OUTLINE: outline_r <= cfg_data;
        REG_RADIUS:  radius_r  <= cfg_data[RADIUS_W-1:0];
        REG_WIDTH:   width_r   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:  height_r  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index <= REG_HEIGHT);

  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [RDW-1:0] r_eff;
  logic [LW-1:0]  lag;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WEW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HEW'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(height_r);
    end
    if (int'(radius_r) > MAX_RADIUS) begin
      r_eff = RDW'(MAX_RADIUS);
    end else begin
      r_eff = RDW'(radius_r);
    end
    lag = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);
  end

  // output register and pipeline advance
  logic             out_v_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;
  logic             adv;

  assign adv = !out_v_r || out_ch.ready;

  // position sequencing
  cod_step_t     ctl;
  logic [CW-1:0] pcol;
  logic [RW-1:0] prow;
  logic [PW-1:0] wptr, rptr;

  cod_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart_i (restart),
    .adv_i     (adv),
    .in_valid_i(in_ch.valid),
    .req_type_i(in_ch.req_type),
    .w_i       (w_eff),
    .h_i       (h_eff),
    .lag_i     (lag),
    .in_ready_o(in_ch.ready),
    .ctl_o     (ctl),
    .pcol_o    (pcol),
    .prow_o    (prow),
    .wptr_o    (wptr),
    .rptr_o    (rptr)
  );

  // stage B registers
  logic             b_valid_r, b_emit_r, b_last_r, b_flag_r, b_fbit_r;
  logic [CW-1:0]    b_col_r;
  logic [RW-1:0]    b_row_r;
  logic             b_mfwd_r, b_pfwd_r;
  logic [MVW-1:0]   b_mvec_r;
  logic [PIX_W-1:0] b_ppix_r;

  logic [MVW-1:0]   m_q, b_newvec, vec_in;
  logic [PIX_W-1:0] p_q, pix_b;
  logic [VW-1:0]    full, vmask;
  logic             b_vor, b_wr, a_flag;

  assign a_flag = ctl.real_pix && (in_ch.pixel_in == match_r);
  assign b_wr   = adv && b_valid_r;

  cod_ram #(.WIDTH(MVW), .DEPTH(MAX_WIDTH)) u_col_ram (
    .clk  (clk),
    .we   (b_wr),
    .waddr(b_col_r),
    .wdata(b_newvec),
    .re   (ctl.step),
    .raddr(pcol),
    .rdata(m_q)
  );

  cod_ram #(.WIDTH(PIX_W), .DEPTH(PD)) u_pix_ram (
    .clk  (clk),
    .we   (ctl.real_pix),
    .waddr(wptr),
    .wdata(in_ch.pixel_in),
    .re   (ctl.emit),
    .raddr(rptr),
    .rdata(p_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_emit_r  <= 1'b0;
    end else if (adv) begin
      b_valid_r <= ctl.step;
      b_emit_r  <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_last_r <= ctl.last;
      b_flag_r <= a_flag;
      b_fbit_r <= ctl.fbit;
      b_col_r  <= pcol;
      b_row_r  <= prow;
      b_mfwd_r <= b_valid_r && ctl.step && (b_col_r == pcol);
      b_mvec_r <= b_newvec;
      b_pfwd_r <= ctl.real_pix && ctl.emit && (wptr == rptr);
      b_ppix_r <= in_ch.pixel_in;
    end
  end

  // column vector: bit k is the match flag k lines above
  always_comb begin
    vec_in = b_mfwd_r ? b_mvec_r : m_q;
    full   = {vec_in, b_flag_r};
    for (int k = 0; k < VW; k++) begin
      vmask[k] = (k <= 2 * int'(r_eff)) && (k <= int'(b_row_r));
    end
    b_vor    = |(full & vmask);
    b_newvec = full[MVW-1:0];
    pix_b    = b_pfwd_r ? b_ppix_r : p_q;
  end

  // window chain
  logic             c_valid [NC];
  logic             c_vor   [NC];
  logic             c_fbit  [NC];
  logic [RW-1:0]    c_row   [NC];
  logic [NC-1:0]    hits, win;
  logic [RW-1:0]    ctr_row;
  logic             ctr_fbit;

  assign ctr_row  = c_row[NCW'(r_eff)];
  assign ctr_fbit = c_fbit[NCW'(r_eff)];

  for (genvar j = 0; j < NC; j++) begin : g_cell
    assign win[j] = (j <= 2 * int'(r_eff));
    if (j == 0) begin : g_head
      cod_cell #(.RW(RW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr_i     (restart),
        .en_i      (b_wr),
        .d_valid_i (b_valid_r),
        .d_vor_i   (b_vor),
        .d_fbit_i  (b_fbit_r),
        .d_row_i   (b_row_r),
        .q_valid_o (c_valid[j]),
        .q_vor_o   (c_vor[j]),
        .q_fbit_o  (c_fbit[j]),
        .q_row_o   (c_row[j]),
        .ctr_row_i (ctr_row),
        .ctr_fbit_i(ctr_fbit),
        .win_i     (win[j]),
        .hit_o     (hits[j])
      );
    end else begin : g_body
      cod_cell #(.RW(RW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr_i     (restart),
        .en_i      (b_wr),
        .d_valid_i (c_valid[j-1]),
        .d_vor_i   (c_vor[j-1]),
        .d_fbit_i  (c_fbit[j-1]),
        .d_row_i   (c_row[j-1]),
        .q_valid_o (c_valid[j]),
        .q_vor_o   (c_vor[j]),
        .q_fbit_o  (c_fbit[j]),
        .q_row_o   (c_row[j]),
        .ctr_row_i (ctr_row),
        .ctr_fbit_i(ctr_fbit),
        .win_i     (win[j]),
        .hit_o     (hits[j])
      );
    end
  end

  // stage C
  logic             c_emit_r, c_last_r;
  logic [PIX_W-1:0] c_pix_r, res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_emit_r <= 1'b0;
    end else if (adv) begin
      c_emit_r <= b_valid_r && b_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_last_r <= b_last_r;
      c_pix_r  <= pix_b;
    end
  end

  assign res = ((c_pix_r != match_r) && (|hits)) ? outline_r : c_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= c_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r  <= res;
      out_last_r <= c_last_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.pixel_out     = out_pix_r;
  assign out_ch.last_of_frame = out_last_r;

endmodule

// ----- rtl/core/cod_chk.sv -----
// Port-level checks for the colour outline dilation block.
`timescale 1ns / 1ps
module cod_chk
  import cod_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel))
    else $error("result pixel changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind color_outline_dilation cod_chk u_cod_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_pixel(out_ch.pixel_out)
);
